// ===== src/pbhdr_pkg.sv =====
// Package for the protobuf packet header parser.
// Holds the field widths, the result record, the emit flags and the result queue depth.
// No dependencies.
package pbhdr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 10;
  localparam int NODE_W = 32;
  localparam int ID_W   = 64;

  localparam int QAW    = 2;
  localparam int QDEPTH = 1 << QAW;
  localparam int QCW    = QAW + 1;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [ID_W-1:0]   packet_id;
    logic [NODE_W-1:0] channel_value;
    logic [NODE_W-1:0] hop_cap;
    logic [NODE_W-1:0] hop_init;
    logic              ack_req;
    logic              last_of_run;
  } pbhdr_res_t;

  typedef struct packed {
    logic pay;
    logic sum;
  } pbhdr_emit_t;

endpackage

// ===== src/pbhdr_if.sv =====
// Valid/ready channel interfaces for the protobuf packet header parser.
// Depends on pbhdr_pkg for the field widths.
interface pbhdr_in_if import pbhdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic [LEN_W-1:0]  msg_length;

  modport source (output valid, output in_byte, output msg_length, input ready);
  modport sink (input valid, input in_byte, input msg_length, output ready);
endinterface

interface pbhdr_out_if import pbhdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] payload_byte;
  logic [NODE_W-1:0] from_node;
  logic [NODE_W-1:0] to_node;
  logic [ID_W-1:0]   packet_id;
  logic [NODE_W-1:0] channel_value;
  logic [NODE_W-1:0] hop_cap;
  logic [NODE_W-1:0] hop_init;
  logic              ack_req;
  logic              last_of_run;

  modport source (output valid, output kind, output payload_byte, output from_node,
                  output to_node, output packet_id, output channel_value,
                  output hop_cap, output hop_init, output ack_req,
                  output last_of_run, input ready);
  modport sink (input valid, input kind, input payload_byte, input from_node,
                input to_node, input packet_id, input channel_value,
                input hop_cap, input hop_init, input ack_req,
                input last_of_run, output ready);
endinterface

// ===== src/pbhdr_core.sv =====
// Byte-at-a-time protobuf wire format decoder state and the per-byte next-state logic.
// Depends on pbhdr_pkg for widths and the result record.
module pbhdr_core import pbhdr_pkg::*; #(
  parameter int MAX_MSG_BYTES = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic [LEN_W-1:0]  msg_length,
  output pbhdr_emit_t       emit,
  output pbhdr_res_t        pay_res,
  output pbhdr_res_t        sum_res
);

  localparam int LW = $clog2(MAX_MSG_BYTES + 1);
  localparam int CW = (LW > LEN_W) ? LW : LEN_W;

  localparam logic [2:0] PH_TAG     = 3'd0;
  localparam logic [2:0] PH_VALUE   = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;
  localparam logic [2:0] PH_FIXED   = 3'd5;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic [NODE_W-1:0] FN_FROM  = 32'd1;
  localparam logic [NODE_W-1:0] FN_TO    = 32'd2;
  localparam logic [NODE_W-1:0] FN_ENC   = 32'd4;
  localparam logic [NODE_W-1:0] FN_ID    = 32'd6;
  localparam logic [NODE_W-1:0] FN_CHAN  = 32'd7;
  localparam logic [NODE_W-1:0] FN_HLIM  = 32'd8;
  localparam logic [NODE_W-1:0] FN_HSTRT = 32'd9;
  localparam logic [NODE_W-1:0] FN_ACK   = 32'd10;

  function automatic logic is_kept(input logic [NODE_W-1:0] fn);
    return fn inside {FN_FROM, FN_TO, FN_ID, FN_CHAN, FN_HLIM, FN_HSTRT, FN_ACK};
  endfunction

  logic [2:0]        phase_r, phase_stp, phase_nxt;
  logic [ID_W-1:0]   acc_r, acc_stp, acc_nxt;
  logic [3:0]        vcnt_r, vcnt_stp, vcnt_nxt;
  logic [NODE_W-1:0] fnum_r, fnum_stp, fnum_nxt;
  logic [LW-1:0]     left_r, left_nxt;
  logic [LW-1:0]     span_r, span_stp, span_nxt;
  logic [NODE_W-1:0] from_r, from_stp, from_nxt;
  logic [NODE_W-1:0] to_r, to_stp, to_nxt;
  logic [ID_W-1:0]   id_r, id_stp, id_nxt;
  logic [NODE_W-1:0] chan_r, chan_stp, chan_nxt;
  logic [NODE_W-1:0] hlim_r, hlim_stp, hlim_nxt;
  logic [NODE_W-1:0] hstrt_r, hstrt_stp, hstrt_nxt;
  logic              ack_r, ack_stp, ack_nxt;

  logic [CW-1:0]     ml_ext, ml_nz;
  logic [LW-1:0]     len_c, cur_left, rem;
  logic [6:0]        sh7;
  logic [ID_W-1:0]   vshift, fshift, vval;
  logic [3:0]        vcnt_inc;
  logic              vdone, len_ok, msg_end;
  logic [NODE_W-1:0] tag_fn;
  logic [2:0]        tag_wk;
  logic              tag_known;
  logic [LW-1:0]     span_dec;
  logic              store_en, id_fixed_en, pay_emit;
  logic [NODE_W-1:0] store_fn;
  logic [ID_W-1:0]   store_val;

  always_comb begin
    ml_ext   = CW'(msg_length);
    ml_nz    = (ml_ext == '0) ? CW'(1) : ml_ext;
    len_c    = (ml_nz > CW'(MAX_MSG_BYTES)) ? LW'(MAX_MSG_BYTES) : ml_nz[LW-1:0];
    cur_left = (left_r == '0) ? len_c : left_r;
    rem      = cur_left - LW'(1);
    msg_end  = (rem == '0);

    sh7      = {vcnt_r, 3'b000} - {3'b000, vcnt_r};
    vshift   = (sh7 < 7'd64) ? ({{(ID_W-7){1'b0}}, in_byte[6:0]} << sh7[5:0]) : '0;
    fshift   = (vcnt_r < 4'd8) ?
               ({{(ID_W-BYTE_W){1'b0}}, in_byte} << {vcnt_r[2:0], 3'b000}) : '0;
    vval     = acc_r | vshift;
    vcnt_inc = vcnt_r + 4'd1;
    vdone    = !in_byte[7] || (vcnt_inc >= 4'd10) || msg_end;
    len_ok   = (vval != '0) && (vval[ID_W-1:LW] == '0) && (vval[LW-1:0] <= rem);
    tag_fn   = vval[NODE_W+2:3];
    tag_wk   = vval[2:0];
    tag_known = is_kept(tag_fn) || (tag_fn == FN_ENC);
    span_dec = (span_r != '0) ? span_r - LW'(1) : span_r;

    phase_stp   = phase_r;
    acc_stp     = acc_r;
    vcnt_stp    = vcnt_r;
    fnum_stp    = fnum_r;
    span_stp    = span_r;
    store_en    = 1'b0;
    store_fn    = fnum_r;
    store_val   = '0;
    id_fixed_en = 1'b0;
    pay_emit    = 1'b0;

    case (phase_r)
      PH_TAG, PH_VALUE, PH_LEN: begin
        acc_stp  = vval;
        vcnt_stp = vcnt_inc;
        if (vdone) begin
          acc_stp   = '0;
          vcnt_stp  = '0;
          phase_stp = PH_TAG;
          if (phase_r == PH_TAG) begin
            fnum_stp = tag_fn;
            if (tag_known) begin
              if (tag_wk == WT_VARINT && tag_fn != FN_ENC) begin
                if (msg_end) begin
                  store_en = 1'b1;
                  store_fn = tag_fn;
                end else begin
                  phase_stp = PH_VALUE;
                end
              end else if (tag_fn == FN_ENC && tag_wk == WT_LEN) begin
                if (!msg_end) begin
                  phase_stp = PH_LEN;
                end
              end else if (tag_fn == FN_ID && tag_wk == WT_FIXED64) begin
                if (rem >= LW'(8)) begin
                  phase_stp = PH_FIXED;
                end
              end
            end else begin
              if (tag_wk == WT_VARINT || tag_wk == WT_LEN) begin
                if (!msg_end) begin
                  phase_stp = (tag_wk == WT_VARINT) ? PH_VALUE : PH_LEN;
                end
              end else if (tag_wk == WT_FIXED64 && rem >= LW'(8)) begin
                phase_stp = PH_SKIP;
                span_stp  = LW'(8);
              end else if (tag_wk == WT_FIXED32 && rem >= LW'(4)) begin
                phase_stp = PH_SKIP;
                span_stp  = LW'(4);
              end
            end
          end else if (phase_r == PH_VALUE) begin
            if (is_kept(fnum_r)) begin
              store_en  = 1'b1;
              store_val = vval;
            end
          end else if (len_ok) begin
            span_stp  = vval[LW-1:0];
            phase_stp = (fnum_r == FN_ENC) ? PH_PAYLOAD : PH_SKIP;
          end
        end
      end
      PH_PAYLOAD, PH_SKIP: begin
        pay_emit = (phase_r == PH_PAYLOAD);
        span_stp = span_dec;
        if (span_dec == '0) begin
          phase_stp = PH_TAG;
        end
      end
      PH_FIXED: begin
        acc_stp  = acc_r | fshift;
        vcnt_stp = vcnt_inc;
        if (vcnt_inc >= 4'd8) begin
          id_fixed_en = 1'b1;
          acc_stp     = '0;
          vcnt_stp    = '0;
          phase_stp   = PH_TAG;
        end
      end
      default: begin
        phase_stp = PH_TAG;
      end
    endcase

    from_stp  = from_r;
    to_stp    = to_r;
    id_stp    = id_r;
    chan_stp  = chan_r;
    hlim_stp  = hlim_r;
    hstrt_stp = hstrt_r;
    ack_stp   = ack_r;
    if (store_en) begin
      case (store_fn)
        FN_FROM:  from_stp  = store_val[NODE_W-1:0];
        FN_TO:    to_stp    = store_val[NODE_W-1:0];
        FN_ID:    id_stp    = store_val;
        FN_CHAN:  chan_stp  = store_val[NODE_W-1:0];
        FN_HLIM:  hlim_stp  = store_val[NODE_W-1:0];
        FN_HSTRT: hstrt_stp = store_val[NODE_W-1:0];
        FN_ACK:   ack_stp   = (store_val != '0);
        default: ;
      endcase
    end
    if (id_fixed_en) begin
      id_stp = acc_r | fshift;
    end

    left_nxt = rem;
    if (msg_end) begin
      phase_nxt = PH_TAG;
      acc_nxt   = '0;
      vcnt_nxt  = '0;
      fnum_nxt  = '0;
      span_nxt  = '0;
      from_nxt  = '0;
      to_nxt    = '0;
      id_nxt    = '0;
      chan_nxt  = '0;
      hlim_nxt  = '0;
      hstrt_nxt = '0;
      ack_nxt   = 1'b0;
    end else begin
      phase_nxt = phase_stp;
      acc_nxt   = acc_stp;
      vcnt_nxt  = vcnt_stp;
      fnum_nxt  = fnum_stp;
      span_nxt  = span_stp;
      from_nxt  = from_stp;
      to_nxt    = to_stp;
      id_nxt    = id_stp;
      chan_nxt  = chan_stp;
      hlim_nxt  = hlim_stp;
      hstrt_nxt = hstrt_stp;
      ack_nxt   = ack_stp;
    end

    emit.pay = fire && pay_emit;
    emit.sum = fire && msg_end;

    pay_res              = '0;
    pay_res.kind         = 1'b0;
    pay_res.payload_byte = in_byte;
    pay_res.last_of_run  = !msg_end;

    sum_res               = '0;
    sum_res.kind          = 1'b1;
    sum_res.from_node     = from_stp;
    sum_res.to_node       = to_stp;
    sum_res.packet_id     = id_stp;
    sum_res.channel_value = chan_stp;
    sum_res.hop_cap       = hlim_stp;
    sum_res.hop_init      = hstrt_stp;
    sum_res.ack_req       = ack_stp;
    sum_res.last_of_run   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      acc_r   <= '0;
      vcnt_r  <= '0;
      fnum_r  <= '0;
      left_r  <= '0;
      span_r  <= '0;
      from_r  <= '0;
      to_r    <= '0;
      id_r    <= '0;
      chan_r  <= '0;
      hlim_r  <= '0;
      hstrt_r <= '0;
      ack_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      vcnt_r  <= vcnt_nxt;
      fnum_r  <= fnum_nxt;
      left_r  <= left_nxt;
      span_r  <= span_nxt;
      from_r  <= from_nxt;
      to_r    <= to_nxt;
      id_r    <= id_nxt;
      chan_r  <= chan_nxt;
      hlim_r  <= hlim_nxt;
      hstrt_r <= hstrt_nxt;
      ack_r   <= ack_nxt;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    left_r == '0 |-> phase_r == PH_TAG && acc_r == '0 && vcnt_r == '0 &&
                     from_r == '0 && id_r == '0 && ack_r == 1'b0)
    else $error("Parser state not cleared between messages.");

  a_span_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> span_r != '0 && span_r <= left_r)
    else $error("Payload span is empty or runs past the message end.");

  a_varint_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TAG || phase_r == PH_VALUE || phase_r == PH_LEN) |-> vcnt_r < 4'd10)
    else $error("Varint byte count exceeded ten.");

  a_sum_ends: assert property (@(posedge clk) disable iff (!rst_n)
    emit.sum |=> left_r == '0)
    else $error("Summary issued without closing the message.");

endmodule

// ===== src/pbhdr_outq.sv =====
// Four-entry result queue that takes up to two results per transaction and returns one.
// Depends on pbhdr_pkg for the result record, the emit flags and the depth.
module pbhdr_outq import pbhdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  pbhdr_emit_t emit,
  input  pbhdr_res_t  pay_res,
  input  pbhdr_res_t  sum_res,
  output logic        room,
  output logic        head_valid,
  input  logic        head_ready,
  output pbhdr_res_t  head
);

  pbhdr_res_t     q_r [QDEPTH];
  logic [QAW-1:0] head_r, head_nxt;
  logic [QAW-1:0] tail_r, tail_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic [1:0]     push_n;
  logic           pop;
  pbhdr_res_t     first;

  always_comb begin
    push_n     = {1'b0, emit.pay} + {1'b0, emit.sum};
    first      = emit.pay ? pay_res : sum_res;
    head_valid = (count_r != '0);
    pop        = head_valid && head_ready;
    head       = q_r[head_r];
    room       = (count_r <= QCW'(QDEPTH - 2));
    count_nxt  = count_r + QCW'(push_n) - QCW'(pop);
    tail_nxt   = tail_r + QAW'(push_n);
    head_nxt   = head_r + QAW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[tail_r] <= first;
    end
    if (push_n == 2'd2) begin
      q_r[tail_r + QAW'(1)] <= sum_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("Result queue overflow.");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.pay || emit.sum) |-> room)
    else $error("Results pushed while the queue lacked room for two.");

  a_pair_lands: assert property (@(posedge clk) disable iff (!rst_n)
    emit.pay && emit.sum && !pop |=> count_r >= QCW'(2))
    else $error("A payload and summary pair was not fully queued.");

endmodule

// ===== src/protobuf_packet_header_parser.sv =====
// Top level of the protobuf packet header parser: per-byte decoder and result queue.
// Depends on pbhdr_pkg, pbhdr_if, pbhdr_core and pbhdr_outq.
//
//   port   direction  contents per transaction
//   in_s   sink       in_byte, msg_length (length sampled on a message's first byte)
//   out_s  source     kind, payload_byte, kept header fields, last_of_run
//
// Each input byte is decoded in the cycle it is accepted, so one byte a cycle is taken
// while the queue has room. A byte yields zero, one or two results; these are registered
// into a four-entry queue, whose head is offered one result a cycle while the output
// is ready. Input is taken whenever the queue holds two results or fewer, so a stalled
// output holds the input off once three results wait.
// Reset is synchronous and active low and leaves the parser waiting for a message start.
module protobuf_packet_header_parser import pbhdr_pkg::*; #(
  parameter int MAX_MSG_BYTES = 512
) (
  input logic      clk,
  input logic      rst_n,
  pbhdr_in_if.sink   in_s,
  pbhdr_out_if.source out_s
);

  logic        fire;
  logic        room;
  logic        head_valid;
  pbhdr_emit_t emit;
  pbhdr_res_t  pay_res;
  pbhdr_res_t  sum_res;
  pbhdr_res_t  head;

  assign in_s.ready = room;
  assign fire       = in_s.valid && room;

  pbhdr_core #(
    .MAX_MSG_BYTES(MAX_MSG_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .in_byte   (in_s.in_byte),
    .msg_length(in_s.msg_length),
    .emit      (emit),
    .pay_res   (pay_res),
    .sum_res   (sum_res)
  );

  pbhdr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .pay_res   (pay_res),
    .sum_res   (sum_res),
    .room      (room),
    .head_valid(head_valid),
    .head_ready(out_s.ready),
    .head      (head)
  );

  assign out_s.valid         = head_valid;
  assign out_s.kind          = head.kind;
  assign out_s.payload_byte  = head.payload_byte;
  assign out_s.from_node     = head.from_node;
  assign out_s.to_node       = head.to_node;
  assign out_s.packet_id     = head.packet_id;
  assign out_s.channel_value = head.channel_value;
  assign out_s.hop_cap       = head.hop_cap;
  assign out_s.hop_init      = head.hop_init;
  assign out_s.ack_req       = head.ack_req;
  assign out_s.last_of_run   = head.last_of_run;

endmodule
